[src/assert_macros.svh]
// assertion macros shared by the rasterizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ESR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esr assertion failed");

// antecedent implies consequent in the next cycle
`define ESR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esr assertion failed");

`endif

[src/esr_pkg.sv]
// types and constants for the edge span rasterizer
package esr_pkg;

   localparam int DEF_ROWS       = 160;
   localparam int DEF_COORD_BITS = 10;
   localparam int Y_BITS         = 8;
   localparam int CMD_BITS       = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_DRAW  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_READ_RD,
      ST_CLEAR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic rd_pix;
      logic merge_wr;
      logic rd_row;
      logic clr_row;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type command;
      logic    seg_done;
      logic    rsp_full;
   } dp_sts_type;

endpackage

[src/esr_ctrl.sv]
// controller state machine sequencing draw, read, clear and no-op transactions
`include "assert_macros.svh"

module esr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  rsp_tready,
   input  esr_pkg::dp_sts_type   dp_sts,
   output esr_pkg::dp_cmd_type   dp_cmd
);

   esr_pkg::state_type state_ff;
   esr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      dp_cmd     = '0;
      req_tready = 1'b0;
      case (state_ff)
         esr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = esr_pkg::ST_DECODE;
            end
         end
         esr_pkg::ST_DECODE: begin
            case (dp_sts.command)
               esr_pkg::CMD_DRAW:  state_in = esr_pkg::ST_DRAW_RD;
               esr_pkg::CMD_READ:  state_in = esr_pkg::ST_READ_RD;
               esr_pkg::CMD_CLEAR: state_in = esr_pkg::ST_CLEAR;
               default:            state_in = esr_pkg::ST_RESP;
            endcase
         end
         esr_pkg::ST_DRAW_RD: begin
            dp_cmd.rd_pix = 1'b1;
            state_in      = esr_pkg::ST_DRAW_WR;
         end
         esr_pkg::ST_DRAW_WR: begin
            dp_cmd.merge_wr = 1'b1;
            if (dp_sts.seg_done) begin
               state_in = esr_pkg::ST_RESP;
            end else begin
               state_in = esr_pkg::ST_DRAW_RD;
            end
         end
         esr_pkg::ST_READ_RD: begin
            dp_cmd.rd_row = 1'b1;
            state_in      = esr_pkg::ST_RESP;
         end
         esr_pkg::ST_CLEAR: begin
            dp_cmd.clr_row = 1'b1;
            state_in       = esr_pkg::ST_RESP;
         end
         esr_pkg::ST_RESP: begin
            if (!dp_sts.rsp_full || rsp_tready) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = esr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = esr_pkg::ST_IDLE;
         end
      endcase
   end

   `ESR_ASSERT_NXT(a_accept_decode, clock, reset, req_tvalid && req_tready, state_ff == esr_pkg::ST_DECODE)
   `ESR_ASSERT_NXT(a_walk_continues, clock, reset, (state_ff == esr_pkg::ST_DRAW_WR) && !dp_sts.seg_done, state_ff == esr_pkg::ST_DRAW_RD)

endmodule

[src/esr_datapath.sv]
// datapath: line walk registers, span table memory and result register
`include "assert_macros.svh"

module esr_datapath #(
   parameter int ROWS       = esr_pkg::DEF_ROWS,
   parameter int COORD_BITS = esr_pkg::DEF_COORD_BITS,
   parameter int REQ_W      = 48,
   parameter int RSP_W      = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [REQ_W-1:0]              req_tdata,
   input  logic [esr_pkg::CMD_BITS-1:0]  req_tuser,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [RSP_W-1:0]              rsp_tdata,
   output logic                          rsp_tuser,
   input  esr_pkg::dp_cmd_type           dp_cmd,
   output esr_pkg::dp_sts_type           dp_sts
);

   localparam int C        = COORD_BITS;
   localparam int YB       = esr_pkg::Y_BITS;
   localparam int E        = COORD_BITS + 3;
   localparam int IDX_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic signed [C-1:0] EMPTY_LEFT  = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] EMPTY_RIGHT = {1'b1, {(C-1){1'b0}}};
   localparam logic [YB:0]         ROWS_LIM    = (YB+1)'(ROWS);

   // request fields
   logic signed [C-1:0] in_start_x, in_end_x;
   logic [YB-1:0]       in_start_y, in_end_y, in_row;

   assign in_start_x = req_tdata[C-1:0];
   assign in_start_y = req_tdata[C+YB-1:C];
   assign in_end_x   = req_tdata[2*C+YB-1:C+YB];
   assign in_end_y   = req_tdata[2*C+2*YB-1:2*C+YB];
   assign in_row     = req_tdata[2*C+3*YB-1:2*C+2*YB];

   // walk state
   esr_pkg::cmd_type    cmd_ff;
   logic signed [C-1:0] x_ff, x_in, x_end_ff;
   logic [YB-1:0]       y_ff, y_in, y_end_ff, row_ff;
   logic signed [E-1:0] dx_ff, dy_ff, err_ff, err_in;
   logic                sx_ff, sy_ff;

   logic signed [E-1:0] sx_ext, ex_ext, xdiff, in_dx, in_dy, sy_ext, ey_ext;
   logic signed [E-1:0] e2, err_step;
   logic                step_x, step_y;

   assign sx_ext = {{3{in_start_x[C-1]}}, in_start_x};
   assign ex_ext = {{3{in_end_x[C-1]}}, in_end_x};
   assign xdiff  = ex_ext - sx_ext;
   assign in_dx  = xdiff[E-1] ? -xdiff : xdiff;
   assign sy_ext = {{(E-YB){1'b0}}, in_start_y};
   assign ey_ext = {{(E-YB){1'b0}}, in_end_y};
   assign in_dy  = (in_end_y > in_start_y) ? (sy_ext - ey_ext) : (ey_ext - sy_ext);

   assign e2       = err_ff <<< 1;
   assign step_x   = (e2 >= dy_ff);
   assign step_y   = (e2 <= dx_ff);
   assign err_step = err_ff + (step_x ? dy_ff : '0);
   assign err_in   = err_step + (step_y ? dx_ff : '0);
   assign x_in     = step_x ? (sx_ff ? x_ff + C'(1) : x_ff - C'(1)) : x_ff;
   assign y_in     = step_y ? (sy_ff ? y_ff + YB'(1) : y_ff - YB'(1)) : y_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         cmd_ff   <= esr_pkg::cmd_type'(req_tuser);
         x_ff     <= in_start_x;
         y_ff     <= in_start_y;
         x_end_ff <= in_end_x;
         y_end_ff <= in_end_y;
         row_ff   <= in_row;
         dx_ff    <= in_dx;
         dy_ff    <= in_dy;
         err_ff   <= in_dx + in_dy;
         sx_ff    <= (in_start_x < in_end_x);
         sy_ff    <= (in_start_y < in_end_y);
      end else if (dp_cmd.merge_wr) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         err_ff <= err_in;
      end
   end

   // span table
   logic [2*C-1:0]      mem [ROWS];
   logic [ROWS-1:0]     valid_ff;
   logic [2*C-1:0]      rd_data_ff;
   logic                rd_valid_ff;
   logic                pix_in_range, row_in_range;
   logic [IDX_BITS-1:0] pix_idx, row_idx;
   logic signed [C-1:0] base_left, base_right, new_left, new_right;

   assign pix_in_range = ({1'b0, y_ff} < ROWS_LIM);
   assign row_in_range = ({1'b0, row_ff} < ROWS_LIM);
   assign pix_idx      = IDX_BITS'(y_ff);
   assign row_idx      = IDX_BITS'(row_ff);

   assign base_left  = rd_valid_ff ? rd_data_ff[C-1:0]   : EMPTY_LEFT;
   assign base_right = rd_valid_ff ? rd_data_ff[2*C-1:C] : EMPTY_RIGHT;
   assign new_left   = (x_ff < base_left)  ? x_ff : base_left;
   assign new_right  = (x_ff > base_right) ? x_ff : base_right;

   always_ff @(posedge clock) begin
      if (dp_cmd.merge_wr && pix_in_range) begin
         mem[pix_idx] <= {new_right, new_left};
      end
      if (dp_cmd.rd_pix && pix_in_range) begin
         rd_data_ff <= mem[pix_idx];
      end else if (dp_cmd.rd_row && row_in_range) begin
         rd_data_ff <= mem[row_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.merge_wr && pix_in_range) begin
            valid_ff[pix_idx] <= 1'b1;
         end else if (dp_cmd.clr_row && row_in_range) begin
            valid_ff[row_idx] <= 1'b0;
         end
         if (dp_cmd.rd_pix) begin
            rd_valid_ff <= pix_in_range && valid_ff[pix_idx];
         end else if (dp_cmd.rd_row) begin
            rd_valid_ff <= row_in_range && valid_ff[row_idx];
         end
      end
   end

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [C-1:0] rsp_left_ff, rsp_right_ff, res_left, res_right;
   logic                rsp_present_ff, res_hit;

   assign res_hit      = (cmd_ff == esr_pkg::CMD_READ) && row_in_range;
   assign res_left     = res_hit ? base_left  : '0;
   assign res_right    = res_hit ? base_right : '0;
   assign rsp_valid_in = dp_cmd.load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_rsp) begin
         rsp_left_ff    <= res_left;
         rsp_right_ff   <= res_right;
         rsp_present_ff <= res_hit && (base_right > base_left);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_right_ff, rsp_left_ff});
   assign rsp_tuser  = rsp_present_ff;

   assign dp_sts.command  = cmd_ff;
   assign dp_sts.seg_done = (x_ff == x_end_ff) && (y_ff == y_end_ff);
   assign dp_sts.rsp_full = rsp_valid_ff;

   `ESR_ASSERT_IMP(a_rsp_no_overwrite, clock, reset, dp_cmd.load_rsp, !rsp_valid_ff || rsp_tready)
   `ESR_ASSERT_IMP(a_merge_after_read, clock, reset, dp_cmd.merge_wr, $past(dp_cmd.rd_pix))

endmodule

[src/edge_span_rasterizer_top.sv]
// one transaction at a time; a draw costs one table read-modify-write per pixel,
// done as a pixel read state followed by a merge-write state
// a finished result waits in the output register while the next request is taken
// reset: synchronous, active high; clears control state and the per-row valid bits,
// so every row reads empty at once with no clearing pass
module edge_span_rasterizer_top #(
   parameter int ROWS       = esr_pkg::DEF_ROWS,
   parameter int COORD_BITS = esr_pkg::DEF_COORD_BITS
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                req_tvalid,
   output logic                                                req_tready,
   // start_x, start_y, end_x, end_y, row, zero pad
   input  logic [((2*COORD_BITS+3*esr_pkg::Y_BITS+7)/8)*8-1:0] req_tdata,
   // command
   input  logic [esr_pkg::CMD_BITS-1:0]                        req_tuser,
   output logic                                                rsp_tvalid,
   input  logic                                                rsp_tready,
   // span_left, span_right, zero pad
   output logic [((2*COORD_BITS+7)/8)*8-1:0]                   rsp_tdata,
   // span_present
   output logic                                                rsp_tuser
);

   localparam int REQ_W = ((2*COORD_BITS+3*esr_pkg::Y_BITS+7)/8)*8;
   localparam int RSP_W = ((2*COORD_BITS+7)/8)*8;

   esr_pkg::dp_cmd_type dp_cmd;
   esr_pkg::dp_sts_type dp_sts;

   esr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .dp_sts     (dp_sts),
      .dp_cmd     (dp_cmd)
   );

   esr_datapath #(
      .ROWS       (ROWS),
      .COORD_BITS (COORD_BITS),
      .REQ_W      (REQ_W),
      .RSP_W      (RSP_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

endmodule

[tb/tb_edge_span_rasterizer_top.sv]
// testbench for edge_span_rasterizer_top: directed and random segment, read, clear and no-op traffic
`timescale 1ns / 1ps

module tb_edge_span_rasterizer_top;

   localparam int ROWS        = esr_pkg::DEF_ROWS;
   localparam int COORD_BITS  = esr_pkg::DEF_COORD_BITS;
   localparam int REQ_W       = ((2*COORD_BITS+3*esr_pkg::Y_BITS+7)/8)*8;
   localparam int RSP_W       = ((2*COORD_BITS+7)/8)*8;
   localparam int X_MAX       = 2**(COORD_BITS-1)-1;
   localparam int X_MIN       = -(2**(COORD_BITS-1));
   localparam int Y_MAX       = 2**esr_pkg::Y_BITS-1;
   localparam int EMPTY_LEFT  = X_MAX;
   localparam int EMPTY_RIGHT = X_MIN;

   typedef struct {
      int span_left;
      int span_right;
      bit span_present;
   } span_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_W-1:0]             req_tdata = '0;
   logic [esr_pkg::CMD_BITS-1:0] req_tuser = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_W-1:0]             rsp_tdata;
   logic                         rsp_tuser;

   span_type expected_spans[$];
   int       left_tbl[ROWS];
   int       right_tbl[ROWS];
   int       error_count = 0;
   int       send_idle_pct = 0;
   int       rsp_idle_pct = 0;

   edge_span_rasterizer_top #(
      .ROWS       (ROWS),
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   initial begin
      #(64'd6_000_000 * 12);
      $display("simulation failed");
      $finish;
   end

   function automatic int clamp_int(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // integer line walk, widening the span of every visited row inside the table
   function automatic void trace_segment(input int x0, input int y0, input int x1, input int y1);
      int  dx;
      int  dy;
      int  stepx;
      int  stepy;
      int  err;
      int  e2;
      bit  done;
      dx    = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy    = (y1 > y0) ? y0 - y1 : y1 - y0;
      stepx = (x0 < x1) ? 1 : -1;
      stepy = (y0 < y1) ? 1 : -1;
      err   = dx + dy;
      done  = 1'b0;
      while (!done) begin
         if (y0 >= 0 && y0 < ROWS) begin
            if (x0 < left_tbl[y0]) left_tbl[y0] = x0;
            if (x0 > right_tbl[y0]) right_tbl[y0] = x0;
         end
         if (x0 == x1 && y0 == y1) begin
            done = 1'b1;
         end else begin
            e2 = err * 2;
            if (e2 >= dy) begin
               err += dy;
               x0  += stepx;
            end
            if (e2 <= dx) begin
               err += dx;
               y0  += stepy;
            end
         end
      end
   endfunction

   function automatic span_type apply_command(input esr_pkg::cmd_type cmd, input int sx,
                                              input int sy, input int ex, input int ey,
                                              input int r);
      span_type res;
      res = '{0, 0, 1'b0};
      case (cmd)
         esr_pkg::CMD_DRAW: begin
            trace_segment(sx, sy, ex, ey);
         end
         esr_pkg::CMD_READ: begin
            if (r < ROWS) begin
               res.span_left    = left_tbl[r];
               res.span_right   = right_tbl[r];
               res.span_present = right_tbl[r] > left_tbl[r];
            end
         end
         esr_pkg::CMD_CLEAR: begin
            if (r < ROWS) begin
               left_tbl[r]  = EMPTY_LEFT;
               right_tbl[r] = EMPTY_RIGHT;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t: %s", $time, msg);
   endtask

   task automatic send_item(input esr_pkg::cmd_type cmd, input int sx, input int sy,
                            input int ex, input int ey, input int r);
      logic [COORD_BITS-1:0]     sx_b;
      logic [COORD_BITS-1:0]     ex_b;
      logic [esr_pkg::Y_BITS-1:0] sy_b;
      logic [esr_pkg::Y_BITS-1:0] ey_b;
      logic [esr_pkg::Y_BITS-1:0] r_b;
      sx_b = sx[COORD_BITS-1:0];
      ex_b = ex[COORD_BITS-1:0];
      sy_b = sy[esr_pkg::Y_BITS-1:0];
      ey_b = ey[esr_pkg::Y_BITS-1:0];
      r_b  = r[esr_pkg::Y_BITS-1:0];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      expected_spans.push_back(apply_command(cmd, sx, sy, ex, ey, r));
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({r_b, ey_b, ex_b, sy_b, sx_b});
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off new requests until every pending result has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_spans.size() != 0);
   endtask

   always @(posedge clock) begin : rsp_monitor
      span_type want;
      int       got_left;
      int       got_right;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_left  = $signed(rsp_tdata[COORD_BITS-1:0]);
            got_right = $signed(rsp_tdata[2*COORD_BITS-1:COORD_BITS]);
            if (expected_spans.size() == 0) begin
               report_error("result transaction with no request pending");
            end else begin
               want = expected_spans.pop_front();
               if (got_left != want.span_left)
                  report_error($sformatf("span_left got %0d expected %0d",
                                         got_left, want.span_left));
               if (got_right != want.span_right)
                  report_error($sformatf("span_right got %0d expected %0d",
                                         got_right, want.span_right));
               if (rsp_tuser != want.span_present)
                  report_error($sformatf("span_present got %0b expected %0b",
                                         rsp_tuser, want.span_present));
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic test_empty_after_reset();
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 0);
      send_item(esr_pkg::CMD_READ, -1, 255, -1, 255, ROWS-1);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 80);
   endtask

   task automatic test_segment_shapes();
      // single pixel reads back with no span
      send_item(esr_pkg::CMD_DRAW, 5, 3, 5, 3, 0);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 3);
      send_item(esr_pkg::CMD_DRAW, 100, 10, -20, 10, 0);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 10);
      send_item(esr_pkg::CMD_DRAW, -7, 20, -7, 40, 0);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 30);
      send_item(esr_pkg::CMD_DRAW, 0, 50, 3, 60, 0);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 55);
      send_item(esr_pkg::CMD_DRAW, X_MIN, 70, X_MAX, 72, 0);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 71);
      send_item(esr_pkg::CMD_DRAW, X_MAX, 0, X_MIN, 0, Y_MAX);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 0);
   endtask

   task automatic test_row_bounds();
      send_item(esr_pkg::CMD_DRAW, 10, 150, 30, Y_MAX, 0);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, ROWS-1);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 200);
      send_item(esr_pkg::CMD_DRAW, 0, Y_MAX, X_MIN, 200, 0);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, Y_MAX);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, ROWS);
   endtask

   task automatic test_clear_and_nop();
      send_item(esr_pkg::CMD_CLEAR, 0, 0, 0, 0, 10);
      wait_for_drain();
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 10);
      send_item(esr_pkg::CMD_CLEAR, -1, Y_MAX, -1, Y_MAX, Y_MAX);
      send_item(esr_pkg::CMD_NOP, X_MIN, Y_MAX, X_MAX, 0, 3);
      send_item(esr_pkg::CMD_READ, 0, 0, 0, 0, 3);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int rsp_pct);
      int               pick;
      int               sx;
      int               sy;
      int               ex;
      int               ey;
      int               r;
      esr_pkg::cmd_type cmd;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         sx   = int'($urandom_range(X_MAX - X_MIN)) + X_MIN;
         sy   = ($urandom_range(99) < 80) ? $urandom_range(ROWS-1) : $urandom_range(Y_MAX);
         // mostly short segments, a few with the end point anywhere in the coordinate range
         if ($urandom_range(99) < 85) begin
            ex = clamp_int(sx + int'($urandom_range(80)) - 40, X_MIN, X_MAX);
            ey = clamp_int(sy + int'($urandom_range(40)) - 20, 0, Y_MAX);
         end else begin
            ex = int'($urandom_range(X_MAX - X_MIN)) + X_MIN;
            ey = $urandom_range(Y_MAX);
         end
         r = ($urandom_range(99) < 90) ? $urandom_range(ROWS-1) : $urandom_range(Y_MAX);
         if (pick < 50)      cmd = esr_pkg::CMD_DRAW;
         else if (pick < 85) cmd = esr_pkg::CMD_READ;
         else if (pick < 95) cmd = esr_pkg::CMD_CLEAR;
         else                cmd = esr_pkg::CMD_NOP;
         send_item(cmd, sx, sy, ex, ey, r);
      end
   endtask

   initial begin
      foreach (left_tbl[i]) begin
         left_tbl[i]  = EMPTY_LEFT;
         right_tbl[i] = EMPTY_RIGHT;
      end
      send_idle_pct = 17;
      rsp_idle_pct  = 78;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_after_reset();
      test_segment_shapes();
      test_row_bounds();
      test_clear_and_nop();
      test_random_traffic(150, 17, 78);
      wait_for_drain();
      test_random_traffic(150, 78, 17);
      test_random_traffic(150, 0, 0);
      req_tvalid <= 1'b0;
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
